// ===== sv/pmhd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmhd_pkg
// Types, codes and constants shared by the peak meter with hold and decay.
// ----------------------------------------------------------------------------
package pmhd_pkg;

  localparam int NumChannelsDef = 64;
  localparam int LogSteps       = 29;

  localparam int OpW       = 3;
  localparam int ChannelW  = 6;
  localparam int SampleW   = 16;
  localparam int ClassW    = 2;
  localparam int RangeW    = 16;
  localparam int LevelOutW = 16;
  localparam int LevelW    = 24;
  localparam int HoldW     = 4;
  localparam int StepW     = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;

  localparam logic [OpW-1:0] OpStoreRaw   = 3'd0;
  localparam logic [OpW-1:0] OpStoreQuant = 3'd1;
  localparam logic [OpW-1:0] OpTick       = 3'd2;
  localparam logic [OpW-1:0] OpRead       = 3'd3;
  localparam logic [OpW-1:0] OpClear      = 3'd4;

  localparam logic [ClassW-1:0] ClassNone  = 2'd0;
  localparam logic [ClassW-1:0] ClassThree = 2'd1;
  localparam logic [ClassW-1:0] ClassDiv18 = 2'd2;
  localparam logic [ClassW-1:0] ClassLog   = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgFastDecay = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldTicks = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDecayStep = 2'd2;

  localparam logic             FastDecayRst = 1'b0;
  localparam logic [HoldW-1:0] HoldTicksRst = 4'd3;
  localparam logic [StepW-1:0] DecayStepRst = 8'd154;

  localparam logic [15:0] Div18Mult  = 16'd58255;
  localparam int          Div18Shift = 20;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [HoldW-1:0]  hold;
  } meter_entry_t;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic               match;
    logic [15:0]        value;
    logic               fast_decay;
    logic [HoldW-1:0]   hold_ticks;
    logic [StepW-1:0]   decay_step;
  } head_ctrl_t;

  function automatic logic [15:0] log_threshold(input logic [4:0] k);
    logic [15:0] t;
    case (k)
      5'd0:  t = 16'd2;
      5'd1:  t = 16'd3;
      5'd2:  t = 16'd3;
      5'd3:  t = 16'd5;
      5'd4:  t = 16'd6;
      5'd5:  t = 16'd9;
      5'd6:  t = 16'd13;
      5'd7:  t = 16'd18;
      5'd8:  t = 16'd25;
      5'd9:  t = 16'd36;
      5'd10: t = 16'd51;
      5'd11: t = 16'd73;
      5'd12: t = 16'd104;
      5'd13: t = 16'd149;
      5'd14: t = 16'd213;
      5'd15: t = 16'd304;
      5'd16: t = 16'd434;
      5'd17: t = 16'd620;
      5'd18: t = 16'd886;
      5'd19: t = 16'd1266;
      5'd20: t = 16'd1809;
      5'd21: t = 16'd2585;
      5'd22: t = 16'd3694;
      5'd23: t = 16'd5279;
      5'd24: t = 16'd7545;
      5'd25: t = 16'd10783;
      5'd26: t = 16'd15412;
      5'd27: t = 16'd22027;
      5'd28: t = 16'd31482;
      default: t = 16'hFFFF;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pmhd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmhd_if
// Valid/ready channels of the peak meter: operations, level reads, config.
// ----------------------------------------------------------------------------
interface pmhd_in_if import pmhd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      op;
  logic [ChannelW-1:0] channel;
  logic [SampleW-1:0]  sample_value;
  logic [ClassW-1:0]   scale_class;
  logic [RangeW-1:0]   range_max;

  modport source (output valid, op, channel, sample_value, scale_class, range_max,
                  input ready);
  modport sink (input valid, op, channel, sample_value, scale_class, range_max,
                output ready);
endinterface

interface pmhd_out_if import pmhd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LevelOutW-1:0] level_out;

  modport source (output valid, level_out, input ready);
  modport sink (input valid, level_out, output ready);
endinterface

interface pmhd_cfg_if import pmhd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/channel_peak_meter_hold_decay_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// channel_peak_meter_hold_decay_core
// Per-channel peak meter with hold and decay, kept in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Every tick, read, clear or store makes one full turn of the ring of
// NUM_CHANNELS cells, one channel per cycle; a new item is taken only once
// the last one is through. A raw store first passes a scaling step, which
// repeats per threshold for the logarithmic class; a quantized store runs
// the divider ahead of its scaling. After a read's turn the output state
// loads the result into the output register once that is free. Reset
// clears all levels and hold counts at once and loads register defaults.
module channel_peak_meter_hold_decay_core import pmhd_pkg::*; #(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pmhd_in_if.sink    in_i,
  pmhd_out_if.source out_o,
  pmhd_cfg_if.sink   cfg_i
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CntW = (IdxW > 5) ? IdxW : 5;
  localparam int CmpW = (CntW > ChannelW) ? CntW : ChannelW;
  localparam logic [CntW-1:0] LastIdx = CntW'(NUM_CHANNELS - 1);
  localparam logic [CntW-1:0] LogLast = CntW'(LogSteps);

  localparam int StW = 3;
  localparam logic [StW-1:0] StIdle  = 3'd0;
  localparam logic [StW-1:0] StDiv   = 3'd1;
  localparam logic [StW-1:0] StScale = 3'd2;
  localparam logic [StW-1:0] StRun   = 3'd3;
  localparam logic [StW-1:0] StOut   = 3'd4;

  logic [StW-1:0]       state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [OpW-1:0]       op_q, op_d;
  logic [ChannelW-1:0]  ch_q, ch_d;
  logic [ClassW-1:0]    cls_q, cls_d;
  logic [15:0]          a_q, a_d;
  logic [LevelOutW-1:0] rd_q, rd_d;
  logic                 out_valid_q, out_valid_d;
  logic [LevelOutW-1:0] out_data_q, out_data_d;
  logic                 fast_q;
  logic [HoldW-1:0]     hold_ticks_q;
  logic [StepW-1:0]     decay_step_q;

  logic                 in_fire;
  logic                 neg;
  logic [15:0]          mag;
  logic [15:0]          clip;
  logic                 div_start;
  logic                 div_done;
  logic [3:0]           div_quot;
  logic [17:0]          prod3;
  logic [31:0]          prod18;
  logic                 match;
  logic                 shift;
  head_ctrl_t           head_ctrl;
  meter_entry_t         head_out;
  meter_entry_t         cell_in   [NUM_CHANNELS];
  meter_entry_t         cell_data [NUM_CHANNELS];

  assign in_i.ready  = (state_q == StIdle);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign neg  = in_i.sample_value[SampleW-1];
  assign mag  = neg ? (~in_i.sample_value + 16'd1) : in_i.sample_value;
  assign clip = neg ? 16'd0 :
                ((in_i.sample_value > in_i.range_max) ? in_i.range_max : in_i.sample_value);
  assign div_start = in_fire && (in_i.op == OpStoreQuant);

  pmhd_qdiv u_qdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .level_i     (clip),
    .range_max_i (in_i.range_max),
    .done_o      (div_done),
    .quot_o      (div_quot)
  );

  assign prod3  = 18'(a_q) * 18'd3;
  assign prod18 = 32'(a_q) * 32'(Div18Mult);

  assign match = (CmpW'(cnt_q) == CmpW'(ch_q));
  assign shift = (state_q == StRun);

  assign head_ctrl.op         = op_q;
  assign head_ctrl.match      = match;
  assign head_ctrl.value      = a_q;
  assign head_ctrl.fast_decay = fast_q;
  assign head_ctrl.hold_ticks = hold_ticks_q;
  assign head_ctrl.decay_step = decay_step_q;

  pmhd_head u_head (
    .ctrl_i  (head_ctrl),
    .entry_i (cell_data[0]),
    .entry_o (head_out)
  );

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
    if (g == NUM_CHANNELS - 1) begin : g_tail
      assign cell_in[g] = head_out;
    end else begin : g_link
      assign cell_in[g] = cell_data[g+1];
    end
    pmhd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .data_i  (cell_in[g]),
      .data_o  (cell_data[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    ch_d        = ch_q;
    cls_d       = cls_q;
    a_d         = a_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          op_d  = in_i.op;
          ch_d  = in_i.channel;
          cls_d = in_i.scale_class;
          a_d   = mag;
          rd_d  = '0;
          cnt_d = '0;
          case (in_i.op) inside
            OpStoreRaw:              state_d = StScale;
            OpStoreQuant:            state_d = StDiv;
            OpTick, OpRead, OpClear: state_d = StRun;
            default:                 state_d = StIdle;
          endcase
        end
      end
      StDiv: begin
        if (div_done) begin
          a_d     = {12'd0, div_quot};
          state_d = StScale;
        end
      end
      StScale: begin
        case (cls_q)
          ClassLog: begin
            if ((cnt_q < LogLast) && (a_q >= log_threshold(cnt_q[4:0]))) begin
              cnt_d = cnt_q + CntW'(1);
            end else begin
              a_d     = 16'(cnt_q);
              cnt_d   = '0;
              state_d = StRun;
            end
          end
          ClassThree: begin
            a_d     = prod3[17:2];
            state_d = StRun;
          end
          ClassDiv18: begin
            a_d     = 16'(prod18 >> Div18Shift);
            state_d = StRun;
          end
          default: begin
            state_d = StRun;
          end
        endcase
      end
      StRun: begin
        if (match && (op_q == OpRead)) begin
          rd_d = cell_data[0].level[LevelW-1 -: LevelOutW];
        end
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = (op_q == OpRead) ? StOut : StIdle;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      StOut: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      op_q        <= '0;
      ch_q        <= '0;
      cls_q       <= '0;
      a_q         <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      op_q        <= op_d;
      ch_q        <= ch_d;
      cls_q       <= cls_d;
      a_q         <= a_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q       <= FastDecayRst;
      hold_ticks_q <= HoldTicksRst;
      decay_step_q <= DecayStepRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CfgFastDecay: fast_q       <= cfg_i.data[0];
        CfgHoldTicks: hold_ticks_q <= cfg_i.data[HoldW-1:0];
        CfgDecayStep: decay_step_q <= cfg_i.data[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.level_out = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (cnt_q <= LastIdx))
    else $error("ring index ran past the last channel");

  a_read_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && cnt_q == LastIdx && op_q == OpRead) |=> (state_q == StOut))
    else $error("read transaction did not reach the output stage");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider finished outside the divide state");

  a_ring_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StRun) |=> $stable(cell_data[0]))
    else $error("head cell changed while the ring was stopped");

endmodule
`default_nettype wire

// ===== sv/pmhd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmhd_cell
// One meter channel's level and hold count, passed on to the next cell.
// ----------------------------------------------------------------------------
module pmhd_cell import pmhd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire meter_entry_t data_i,
  output meter_entry_t data_o
);

  meter_entry_t data_q;
  meter_entry_t data_d;

  assign data_d = shift_i ? data_i : data_q;
  assign data_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pmhd_head.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmhd_head
// Update applied to the channel entry at the head of the cell ring.
// ----------------------------------------------------------------------------
module pmhd_head import pmhd_pkg::*; (
  input  wire head_ctrl_t   ctrl_i,
  input  wire meter_entry_t entry_i,
  output meter_entry_t entry_o
);

  logic [LevelW-1:0] new_level;
  logic [LevelW-1:0] step_ext;

  assign new_level = {ctrl_i.value, 8'h00};
  assign step_ext  = {{(LevelW-StepW){1'b0}}, ctrl_i.decay_step};

  always_comb begin
    entry_o = entry_i;
    case (ctrl_i.op) inside
      OpStoreRaw, OpStoreQuant: begin
        if (ctrl_i.match && (new_level >= entry_i.level)) begin
          entry_o.level = new_level;
          entry_o.hold  = ctrl_i.hold_ticks;
        end
      end
      OpTick: begin
        if (entry_i.hold != '0) begin
          entry_o.hold = ctrl_i.fast_decay ? '0 : entry_i.hold - HoldW'(1);
        end else if (entry_i.level != '0) begin
          if (ctrl_i.fast_decay || (entry_i.level <= step_ext)) begin
            entry_o.level = '0;
          end else begin
            entry_o.level = entry_i.level - step_ext;
          end
        end
      end
      OpClear: begin
        entry_o = '0;
      end
      default: begin
        entry_o = entry_i;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/pmhd_qdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmhd_qdiv
// Four-step restoring divider mapping a clipped level onto 0..15.
// ----------------------------------------------------------------------------
module pmhd_qdiv import pmhd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RangeW-1:0] level_i,
  input  wire logic [RangeW-1:0] range_max_i,
  output logic                   done_o,
  output logic [3:0]             quot_o
);

  logic [RangeW:0]   rem_q, rem_d;
  logic [RangeW:0]   div_q, div_d;
  logic [3:0]        quot_q, quot_d;
  logic [1:0]        step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              nz_q, nz_d;
  logic [RangeW+1:0] rem2;
  logic [RangeW+1:0] div_ext;

  assign rem2    = {rem_q, 1'b0};
  assign div_ext = {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    nz_d   = nz_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, level_i};
      div_d  = {1'b0, range_max_i} + (RangeW+1)'(1);
      quot_d = '0;
      step_d = '0;
      busy_d = 1'b1;
      nz_d   = (level_i != '0);
    end else if (busy_q) begin
      if (rem2 >= div_ext) begin
        rem_d  = (RangeW+1)'(rem2 - div_ext);
        quot_d = {quot_q[2:0], 1'b1};
      end else begin
        rem_d  = rem2[RangeW:0];
        quot_d = {quot_q[2:0], 1'b0};
      end
      step_d = step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      quot_q <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      nz_q   <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      div_q  <= div_d;
      quot_q <= quot_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
      nz_q   <= nz_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = (nz_q && (quot_q == 4'd0)) ? 4'd1 : quot_q;

endmodule
`default_nettype wire
